/* hw/rtl/utcep_pkg.sv */
// Package for the UTC date to epoch seconds converter.
// Holds field widths, calendar constants and the month tables used by the day count stage.
// No dependencies.
package utcep_pkg;

    // Default width of the year field (calendar year minus 1900)
    localparam int YEAR_BITS_DEF = 10;

    // Width of the year field on the input stream; YEAR_BITS picks how many are used
    localparam int YEAR_W = 10;

    // Fixed input fields after the year: month, day, hour, minute, second
    localparam int IN_FIXED_W = 26;

    // Output payload widths
    localparam int OUT_W    = 36;
    localparam int M_DATA_W = 40;

    // Seconds within one day as computed from hour/minute/second
    localparam int TOD_W = 17;

    // Calendar constants
    localparam int BASE_YEAR          = 1900;
    localparam int DAYS_1900_TO_1970  = 25567;
    localparam int LEAPS_TO_1899      = 460;
    localparam int SECS_PER_DAY       = 86400;

    // floor(m / 25) = (m * RECIP_25) >> RECIP_SHIFT, exact for m below 43690
    localparam int RECIP_25    = 41944;
    localparam int RECIP_SHIFT = 20;

    // Month codes
    localparam logic [3:0] MONTH_FEB  = 4'd1;
    localparam logic [3:0] MONTH_LAST = 4'd11;

    // Time limits
    localparam logic [4:0] HOUR_LAST   = 5'd23;
    localparam logic [5:0] MINUTE_LAST = 6'd59;

    // Fields carried from stage 1 into the day count
    typedef struct packed {
        logic [3:0]       month;
        logic [4:0]       mday;
        logic [TOD_W-1:0] tod;
        logic             bad;
    } utcep_fields_t;

    // Fields carried from the day count into the scaling stages
    typedef struct packed {
        logic [TOD_W-1:0] tod;
        logic             bad;
    } utcep_tail_t;

    // Length of a month; zero for codes above December
    function automatic logic [4:0] month_len(input logic [3:0] mon, input logic leap);
        logic [4:0] len;
        unique case (mon)
            4'd0, 4'd2, 4'd4, 4'd6, 4'd7, 4'd9, 4'd11: len = 5'd31;
            4'd3, 4'd5, 4'd8, 4'd10:                   len = 5'd30;
            4'd1:                                      len = leap ? 5'd29 : 5'd28;
            default:                                   len = 5'd0;
        endcase
        return len;
    endfunction

    // Days in the year before the first of a month, common year
    function automatic logic [8:0] days_before(input logic [3:0] mon);
        logic [8:0] d;
        unique case (mon)
            4'd0:    d = 9'd0;
            4'd1:    d = 9'd31;
            4'd2:    d = 9'd59;
            4'd3:    d = 9'd90;
            4'd4:    d = 9'd120;
            4'd5:    d = 9'd151;
            4'd6:    d = 9'd181;
            4'd7:    d = 9'd212;
            4'd8:    d = 9'd243;
            4'd9:    d = 9'd273;
            4'd10:   d = 9'd304;
            4'd11:   d = 9'd334;
            default: d = 9'd0;
        endcase
        return d;
    endfunction

endpackage

/* hw/rtl/utc_date_to_epoch_seconds.sv */
// UTC date and time to signed Unix seconds, five-stage pipeline.
// One transfer per cycle when not stalled. The rate is set by the pipeline: every
// stage advances together when the output register is empty or its result is taken;
// the stage-4 day multiplier sits between registers, the stage-1 reciprocal one
// between the input and a register. Reset (aresetn low, synchronous) clears all
// valid bits; payload registers are not reset. Depends on utcep_pkg and stage modules.
module utc_date_to_epoch_seconds
    import utcep_pkg::*;
#(
    parameter int YEAR_BITS = YEAR_BITS_DEF
) (
    input  logic                                        aclk,
    input  logic                                        aresetn,
    input  logic                                        s_axis_tvalid,
    output logic                                        s_axis_tready,
    // year_since_1900, month, day_of_month, hour, minute, second, zero pad
    input  logic [((YEAR_W + IN_FIXED_W + 7) / 8) * 8 - 1:0] s_axis_tdata,
    output logic                                        m_axis_tvalid,
    input  logic                                        m_axis_tready,
    // epoch_seconds, zero pad
    output logic [M_DATA_W-1:0]                         m_axis_tdata,
    // invalid
    output logic                                        m_axis_tuser
);

    localparam int LW = $clog2((1 << YEAR_BITS) + BASE_YEAR) - 2;
    localparam int DW = $clog2(366 * (1 << YEAR_BITS) + 400) + 1;
    localparam int MO = YEAR_W;
    localparam int DO = MO + 4;
    localparam int HO = DO + 5;
    localparam int NO = HO + 5;
    localparam int SO = NO + 6;

    logic                 en;
    logic                 y_valid;
    logic [YEAR_BITS-1:0] y_year;
    logic                 y_leap;
    logic [LW-1:0]        y_leaps;
    utcep_fields_t        y_fields;
    logic                 d_valid;
    logic signed [DW-1:0] d_days;
    utcep_tail_t          d_tail;
    logic                 o_valid;
    logic [OUT_W-1:0]     o_seconds;
    logic                 o_invalid;

    // Advance the whole pipeline when the output register can take a result
    assign en            = !o_valid || m_axis_tready;
    assign s_axis_tready = en;

    utcep_year #(
        .YEAR_BITS(YEAR_BITS),
        .LW       (LW)
    ) u_year (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (s_axis_tvalid),
        .in_year   (YEAR_BITS'(s_axis_tdata[MO-1:0])),
        .in_month  (s_axis_tdata[DO-1:MO]),
        .in_mday   (s_axis_tdata[HO-1:DO]),
        .in_hour   (s_axis_tdata[NO-1:HO]),
        .in_minute (s_axis_tdata[SO-1:NO]),
        .in_second (s_axis_tdata[SO+5:SO]),
        .out_valid (y_valid),
        .out_year  (y_year),
        .out_leap  (y_leap),
        .out_leaps (y_leaps),
        .out_fields(y_fields)
    );

    utcep_days #(
        .YEAR_BITS(YEAR_BITS),
        .LW       (LW),
        .DW       (DW)
    ) u_days (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (en),
        .in_valid (y_valid),
        .in_year  (y_year),
        .in_leap  (y_leap),
        .in_leaps (y_leaps),
        .in_fields(y_fields),
        .out_valid(d_valid),
        .out_days (d_days),
        .out_tail (d_tail)
    );

    utcep_scale #(
        .YEAR_BITS(YEAR_BITS),
        .DW       (DW)
    ) u_scale (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .en         (en),
        .in_valid   (d_valid),
        .in_days    (d_days),
        .in_tail    (d_tail),
        .out_valid  (o_valid),
        .out_seconds(o_seconds),
        .out_invalid(o_invalid)
    );

    assign m_axis_tvalid = o_valid;
    assign m_axis_tdata  = M_DATA_W'(o_seconds);
    assign m_axis_tuser  = o_invalid;

endmodule

/* hw/rtl/utcep_year.sv */
// Stages 1 and 2: year offset, division by 100 through a reciprocal product,
// leap flag and leap day count since 1900, plus time of day and range checks. Depends on utcep_pkg.
module utcep_year
    import utcep_pkg::*;
#(
    parameter int YEAR_BITS = YEAR_BITS_DEF,
    parameter int YFULL_W   = $clog2((1 << YEAR_BITS) + BASE_YEAR),
    parameter int LW        = YFULL_W - 2
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 en,
    input  logic                 in_valid,
    input  logic [YEAR_BITS-1:0] in_year,
    input  logic [3:0]           in_month,
    input  logic [4:0]           in_mday,
    input  logic [4:0]           in_hour,
    input  logic [5:0]           in_minute,
    input  logic [5:0]           in_second,
    output logic                 out_valid,
    output logic [YEAR_BITS-1:0] out_year,
    output logic                 out_leap,
    output logic [LW-1:0]        out_leaps,
    output utcep_fields_t        out_fields
);

    localparam int PW = LW + 16;
    localparam int QW = PW - RECIP_SHIFT;

    // Stage 1 registers
    logic                 v1_reg;
    logic [YEAR_BITS-1:0] y1_reg;
    logic [YFULL_W-1:0]   yf1_reg;
    logic [PW-1:0]        prod1_reg;
    utcep_fields_t        f1_reg;

    // Stage 2 registers
    logic                 v2_reg;
    logic [YEAR_BITS-1:0] y2_reg;
    logic                 leap2_reg;
    logic [LW-1:0]        leaps2_reg;
    utcep_fields_t        f2_reg;

    logic [YFULL_W-1:0] yf_next;
    logic [PW-1:0]      prod_next;
    utcep_fields_t      f_next;

    logic [QW-1:0]      q100;
    logic [LW-1:0]      quarter;
    logic               div4;
    logic               div100;
    logic               div400;
    logic               leap_next;
    logic [LW-1:0]      leaps_next;

    // Stage 1: full year, reciprocal product, early range checks, time of day
    always_comb begin
        yf_next   = YFULL_W'(in_year) + YFULL_W'(BASE_YEAR);
        prod_next = PW'(yf_next[YFULL_W-1:2]) * PW'(RECIP_25);
        f_next.month = in_month;
        f_next.mday  = in_mday;
        f_next.tod   = TOD_W'(in_hour) * TOD_W'(3600) + TOD_W'(in_minute) * TOD_W'(60)
                     + TOD_W'(in_second);
        f_next.bad   = (in_month > MONTH_LAST) || (in_hour > HOUR_LAST)
                     || (in_minute > MINUTE_LAST) || (in_mday == 5'd0);
    end

    // Stage 2: divisibility tests and leap days in 1900 .. year-1
    always_comb begin
        q100    = prod1_reg[PW-1:RECIP_SHIFT];
        quarter = yf1_reg[YFULL_W-1:2];
        div4    = (yf1_reg[1:0] == 2'b00);
        div100  = (yf1_reg == YFULL_W'(YFULL_W'(q100) * YFULL_W'(100)));
        div400  = div100 && (q100[1:0] == 2'b00);
        leap_next  = (div4 && !div100) || div400;
        leaps_next = (quarter - LW'(div4))
                   - (LW'(q100) - LW'(div100))
                   + (LW'(q100 >> 2) - LW'(div400))
                   - LW'(LEAPS_TO_1899);
    end

    // Advance valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
        end
    end

    // Advance payload
    always_ff @(posedge aclk) begin
        if (en) begin
            y1_reg     <= in_year;
            yf1_reg    <= yf_next;
            prod1_reg  <= prod_next;
            f1_reg     <= f_next;
            y2_reg     <= y1_reg;
            leap2_reg  <= leap_next;
            leaps2_reg <= leaps_next;
            f2_reg     <= f1_reg;
        end
    end

    assign out_valid  = v2_reg;
    assign out_year   = y2_reg;
    assign out_leap   = leap2_reg;
    assign out_leaps  = leaps2_reg;
    assign out_fields = f2_reg;

endmodule

/* hw/rtl/utcep_days.sv */
// Stage 3: month length check and signed day count since 1970-01-01.
// Depends on utcep_pkg.
module utcep_days
    import utcep_pkg::*;
#(
    parameter int YEAR_BITS = YEAR_BITS_DEF,
    parameter int LW        = $clog2((1 << YEAR_BITS) + BASE_YEAR) - 2,
    parameter int DW        = $clog2(366 * (1 << YEAR_BITS) + 400) + 1
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 en,
    input  logic                 in_valid,
    input  logic [YEAR_BITS-1:0] in_year,
    input  logic                 in_leap,
    input  logic [LW-1:0]        in_leaps,
    input  utcep_fields_t        in_fields,
    output logic                 out_valid,
    output logic signed [DW-1:0] out_days,
    output utcep_tail_t          out_tail
);

    logic                 v3_reg;
    logic signed [DW-1:0] days3_reg;
    utcep_tail_t          tail3_reg;

    logic [4:0]    mlen;
    logic          feb_adj;
    logic [DW-1:0] days_u;
    utcep_tail_t   tail_next;

    // Validate the day and sum the day count, offset to 1970
    always_comb begin
        mlen    = month_len(in_fields.month, in_leap);
        feb_adj = in_leap && (in_fields.month > MONTH_FEB);
        days_u  = DW'(in_year) * DW'(365) + DW'(in_leaps)
                + DW'(days_before(in_fields.month)) + DW'(feb_adj)
                + DW'(in_fields.mday) - DW'(1) - DW'(DAYS_1900_TO_1970);
        tail_next.tod = in_fields.tod;
        tail_next.bad = in_fields.bad || (in_fields.mday > mlen);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v3_reg <= 1'b0;
        end else if (en) begin
            v3_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            days3_reg <= $signed(days_u);
            tail3_reg <= tail_next;
        end
    end

    assign out_valid = v3_reg;
    assign out_days  = days3_reg;
    assign out_tail  = tail3_reg;

endmodule

/* hw/rtl/utcep_scale.sv */
// Stages 4 and 5: days times seconds per day, then add the time of day.
// Stage 5 is the output register. Depends on utcep_pkg.
module utcep_scale
    import utcep_pkg::*;
#(
    parameter int YEAR_BITS = YEAR_BITS_DEF,
    parameter int DW        = $clog2(366 * (1 << YEAR_BITS) + 400) + 1
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 en,
    input  logic                 in_valid,
    input  logic signed [DW-1:0] in_days,
    input  utcep_tail_t          in_tail,
    output logic                 out_valid,
    output logic [OUT_W-1:0]     out_seconds,
    output logic                 out_invalid
);

    localparam int MW = (DW + 18 > OUT_W) ? DW + 18 : OUT_W;
    localparam logic signed [17:0] SPD = 18'(SECS_PER_DAY);

    logic                 v4_reg;
    logic signed [MW-1:0] prod4_reg;
    utcep_tail_t          tail4_reg;

    logic                 v5_reg;
    logic [OUT_W-1:0]     sec5_reg;
    logic                 bad5_reg;

    logic signed [MW-1:0] prod_next;
    logic [OUT_W-1:0]     sec_next;

    // Scale days to seconds; sum and zero an invalid result
    always_comb begin
        prod_next = in_days * SPD;
        sec_next  = tail4_reg.bad ? '0
                  : prod4_reg[OUT_W-1:0] + OUT_W'(tail4_reg.tod);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end else if (en) begin
            v4_reg <= in_valid;
            v5_reg <= v4_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            prod4_reg <= prod_next;
            tail4_reg <= in_tail;
            sec5_reg  <= sec_next;
            bad5_reg  <= tail4_reg.bad;
        end
    end

    assign out_valid   = v5_reg;
    assign out_seconds = sec5_reg;
    assign out_invalid = bad5_reg;

endmodule
